FILE: design/vbl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbl_pkg: shared types and constants for the voice bulk-dump loader
// Item structs, status codes, message layout constants and the field mask
// table used both when bytes are stored and when fields are decoded.
// ----------------------------------------------------------------------------
package vbl_pkg;

    // Voice store layout
    localparam int NUM_VOICES_DEF = 32;
    localparam int VOICE_BYTES    = 76;
    localparam int BULK_SIZE      = 2432;
    localparam int HEAD_BYTES     = 6;

    // Message length counter
    localparam int LEN_W = 12;
    localparam logic [LEN_W-1:0] LEN_MAX   = 12'hFFF;
    localparam logic [LEN_W-1:0] POS_VOICE = LEN_W'(HEAD_BYTES);
    localparam logic [LEN_W-1:0] POS_CKS   = LEN_W'(HEAD_BYTES + BULK_SIZE);
    localparam logic [LEN_W-1:0] LEN_FULL  = LEN_W'(BULK_SIZE + 12);

    // Header constants
    localparam logic [7:0]  SYX_START   = 8'hF0;
    localparam logic [7:0]  MAKER_ID    = 8'h43;
    localparam logic [7:0]  FORMAT_BULK = 8'h09;
    localparam logic [6:0]  MASK7       = 7'h7F;
    localparam logic [13:0] COUNT_BULK  = 14'(BULK_SIZE);
    localparam logic [8:0]  KEY_BIAS    = 9'd24;
    localparam logic [6:0]  OFF_KEY     = 7'd9;

    // Item kind
    typedef enum logic {
        KIND_BYTE = 1'b0,
        KIND_READ = 1'b1
    } t_kind;

    // Message status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_HEADER    = 3'd2,
        ST_FORMAT    = 3'd3,
        ST_COUNT     = 3'd4,
        ST_CHECKSUM  = 3'd5,
        ST_PROTECTED = 3'd6
    } t_status;

    // Input item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       end_of_message;
        logic [4:0] voice_index;
        logic [6:0] field_offset;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        imported_count;
        logic signed [8:0] field_value;
        logic              field_valid;
    } t_out_item;

    // Bank state and end-of-message outcome from the message checker
    typedef struct packed {
        logic    active_bank;
        logic    loaded;
        t_status status;
    } t_msg_res;

    // Bits kept for each byte of a voice record
    function automatic logic [7:0] field_mask(input logic [6:0] off);
        logic [7:0] m;
        m = 8'h00;
        if (off < 7'd10) begin
            case (off[3:0])
                4'd0, 4'd1: m = 8'h07;
                4'd2:       m = 8'hFF;
                4'd3, 4'd4,
                4'd5:       m = 8'h7F;
                4'd6:       m = 8'h01;
                4'd7:       m = 8'h03;
                4'd8:       m = 8'h73;
                default:    m = 8'hFF;
            endcase
        end else if (off < 7'd74) begin
            case (4'(off - 7'd10))
                4'd0, 4'd1,
                4'd2:       m = 8'h1F;
                4'd3, 4'd4: m = 8'h0F;
                4'd5:       m = 8'hFF;
                4'd6:       m = 8'h03;
                4'd7:       m = 8'h07;
                4'd8:       m = 8'h01;
                4'd9:       m = 8'h07;
                4'd10:      m = 8'hFF;
                4'd11:      m = 8'h3F;
                4'd12:      m = 8'h07;
                default:    m = 8'h00;
            endcase
        end
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: design/vbl_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbl_mem: voice byte store
// Simple dual-port RAM, one write and one registered read per cycle.
// Holds both banks; contents are undefined until written.
// ----------------------------------------------------------------------------
module vbl_mem #(
    parameter int DEPTH = 2 * vbl_pkg::NUM_VOICES_DEF * vbl_pkg::VOICE_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [7:0]         o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: design/vbl_msg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vbl_msg: bulk-dump message checker
// Tracks length, header, byte count, checksum of one message, produces the
// masked voice byte writes into the inactive bank and the end-of-message
// status, and swaps banks on a good dump.
// ----------------------------------------------------------------------------
module vbl_msg #(
    parameter int NUM_VOICES = vbl_pkg::NUM_VOICES_DEF,
    parameter int BANK_BYTES = NUM_VOICES * vbl_pkg::VOICE_BYTES,
    parameter int AW         = $clog2(2 * BANK_BYTES)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_byte_en,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_eom,
    input  wire logic          i_protect,
    output logic               o_we,
    output logic [AW-1:0]      o_waddr,
    output logic [7:0]         o_wdata,
    output vbl_pkg::t_msg_res  o_res
);

    localparam logic [vbl_pkg::LEN_W-1:0] BANK_LEN  = vbl_pkg::LEN_W'(BANK_BYTES);
    localparam logic [6:0]                FLD_LAST  = 7'(vbl_pkg::VOICE_BYTES - 1);

    logic [vbl_pkg::LEN_W-1:0] r_len, n_len;
    logic [6:0]                r_sum, n_sum;
    logic [1:0]                r_herr, n_herr;
    logic [13:0]               r_decl, n_decl;
    logic [7:0]                r_cks, n_cks;
    logic [6:0]                r_fld, n_fld;
    logic                      r_active, r_loaded;

    logic                      take;
    logic                      in_voice;
    logic [vbl_pkg::LEN_W-1:0] vofs;
    vbl_pkg::t_status          st;
    logic                      finish;

    // Per-byte update of the message state
    always_comb begin
        take     = i_byte_en && (r_len != vbl_pkg::LEN_MAX);
        in_voice = (r_len >= vbl_pkg::POS_VOICE) && (r_len < vbl_pkg::POS_CKS);
        vofs     = r_len - vbl_pkg::POS_VOICE;
        n_len    = r_len;
        n_sum    = r_sum;
        n_herr   = r_herr;
        n_decl   = r_decl;
        n_cks    = r_cks;
        n_fld    = r_fld;
        if (take) begin
            n_len = r_len + 1'b1;
            if (r_len == 12'd0 && i_byte != vbl_pkg::SYX_START) begin
                n_herr[0] = 1'b1;
            end
            if (r_len == 12'd1 && i_byte != vbl_pkg::MAKER_ID) begin
                n_herr[0] = 1'b1;
            end
            if (r_len == 12'd3 && i_byte != vbl_pkg::FORMAT_BULK) begin
                n_herr[1] = 1'b1;
            end
            if (r_len == 12'd4) begin
                n_decl = {i_byte[6:0], 7'd0};
            end
            if (r_len == 12'd5) begin
                n_decl = {r_decl[13:7], i_byte[6:0] & vbl_pkg::MASK7};
            end
            if (in_voice) begin
                n_sum = r_sum + i_byte[6:0];
                n_fld = (r_fld == FLD_LAST) ? 7'd0 : r_fld + 1'b1;
            end
            if (r_len == vbl_pkg::POS_CKS) begin
                n_cks = i_byte;
            end
        end
    end

    // Masked voice byte into the inactive bank
    always_comb begin
        o_we    = take && in_voice && (vofs < BANK_LEN);
        o_waddr = (r_active ? AW'(0) : AW'(BANK_BYTES)) + AW'(vofs);
        o_wdata = i_byte & vbl_pkg::field_mask(r_fld);
    end

    // Message checks, in order, on the state including this byte
    always_comb begin
        if (n_len < 12'd8) begin
            st = vbl_pkg::ST_SHORT;
        end else if (n_herr[0]) begin
            st = vbl_pkg::ST_HEADER;
        end else if (n_herr[1]) begin
            st = vbl_pkg::ST_FORMAT;
        end else if (n_len < 12'd10) begin
            st = vbl_pkg::ST_SHORT;
        end else if (n_decl != vbl_pkg::COUNT_BULK) begin
            st = vbl_pkg::ST_COUNT;
        end else if (n_len < vbl_pkg::LEN_FULL) begin
            st = vbl_pkg::ST_SHORT;
        end else if (n_cks != {1'b0, n_sum}) begin
            st = vbl_pkg::ST_CHECKSUM;
        end else if (i_protect) begin
            st = vbl_pkg::ST_PROTECTED;
        end else begin
            st = vbl_pkg::ST_OK;
        end
    end

    assign finish = i_byte_en && i_eom;

    // Message state: cleared after every end byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || finish) begin
            r_len  <= '0;
            r_sum  <= '0;
            r_herr <= '0;
            r_decl <= '0;
            r_cks  <= '0;
            r_fld  <= '0;
        end else begin
            r_len  <= n_len;
            r_sum  <= n_sum;
            r_herr <= n_herr;
            r_decl <= n_decl;
            r_cks  <= n_cks;
            r_fld  <= n_fld;
        end
    end

    // Bank swap on a good dump
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_loaded <= 1'b0;
        end else if (finish && st == vbl_pkg::ST_OK) begin
            r_active <= ~r_active;
            r_loaded <= 1'b1;
        end
    end

    assign o_res.active_bank = r_active;
    assign o_res.loaded      = r_loaded;
    assign o_res.status      = st;

endmodule
`default_nettype wire

FILE: design/sysex_bulk_voice_loader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sysex_bulk_voice_loader: voice bulk-dump receiver with double-buffered store
// Takes message bytes and field reads, stores masked voice bytes and answers
// end-of-message status or decoded voice fields.
// ----------------------------------------------------------------------------
// Items are accepted back to back, one per clock cycle, while results are
// taken. A result (end byte or field read) passes two registers: the accepting
// edge starts the registered read of the voice RAM and loads stage 1, and
// stage 1 moves into the output register, raising o_out_valid, once that
// register is empty or its result is taken. The RAM's registered read sets
// that depth. The input stalls only while stage 1 holds a result behind a held
// output. Bytes that are not the end of a message produce no result. The voice
// RAM holds two banks of NUM_VOICES x 76 bytes; it is not cleared after reset,
// and reads return 0 with field_valid low until a good dump has been loaded.
// The protect register is sampled when the end byte of a message is accepted.
// ----------------------------------------------------------------------------
module sysex_bulk_voice_loader #(
    parameter int NUM_VOICES = vbl_pkg::NUM_VOICES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire vbl_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output vbl_pkg::t_out_item o_out_item,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_data
);

    localparam int BANK_BYTES = NUM_VOICES * vbl_pkg::VOICE_BYTES;
    localparam int DEPTH      = 2 * BANK_BYTES;
    localparam int AW         = $clog2(DEPTH);

    logic              r_protect;
    logic              in_acc;
    logic              byte_en;
    logic              rd_en;
    logic              s1_move;
    vbl_pkg::t_msg_res msg_res;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [7:0]        wdata;
    logic [AW-1:0]     raddr;
    logic [7:0]        rdata;
    logic              rd_valid;
    logic              rd_range;
    logic [4:0]        vi_eff;
    logic [6:0]        off_eff;

    // Stage 1: item waiting on RAM data
    logic              r_s1_valid;
    logic              r_s1_kind;
    logic [2:0]        r_s1_status;
    logic [5:0]        r_s1_count;
    logic              r_s1_fvalid;
    logic              r_s1_range;
    logic [6:0]        r_s1_off;

    // Output register
    logic               r_out_valid;
    vbl_pkg::t_out_item r_out_item;
    vbl_pkg::t_out_item n_out_item;
    logic [7:0]         fmask;
    logic [8:0]         key_val;

    // Configuration: always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protect <= 1'b0;
        end else if (i_cfg_valid) begin
            r_protect <= i_cfg_data;
        end
    end

    // Handshake and pipeline advance
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;
    assign byte_en    = in_acc && (i_in_item.kind == vbl_pkg::KIND_BYTE);
    assign rd_en      = in_acc && (i_in_item.kind == vbl_pkg::KIND_READ);

    // Message checker and bank control
    vbl_msg #(
        .NUM_VOICES (NUM_VOICES),
        .BANK_BYTES (BANK_BYTES),
        .AW         (AW)
    ) u_msg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (byte_en),
        .i_byte    (i_in_item.data_byte),
        .i_eom     (i_in_item.end_of_message),
        .i_protect (r_protect),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_res     (msg_res)
    );

    // Read address in the active bank; out-of-range reads are forced to 0
    always_comb begin
        rd_valid = msg_res.loaded && (32'(i_in_item.voice_index) < NUM_VOICES);
        rd_range = rd_valid && (i_in_item.field_offset < 7'(vbl_pkg::VOICE_BYTES));
        vi_eff   = rd_range ? i_in_item.voice_index : 5'd0;
        off_eff  = rd_range ? i_in_item.field_offset : 7'd0;
        raddr    = (msg_res.active_bank ? AW'(BANK_BYTES) : AW'(0))
                 + AW'(vi_eff) * AW'(vbl_pkg::VOICE_BYTES)
                 + AW'(off_eff);
    end

    vbl_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= rd_en || i_in_item.end_of_message;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind   <= i_in_item.kind;
            r_s1_status <= rd_en ? 3'(vbl_pkg::ST_OK) : 3'(msg_res.status);
            r_s1_count  <= (!rd_en && msg_res.status == vbl_pkg::ST_OK)
                         ? 6'(NUM_VOICES) : 6'd0;
            r_s1_fvalid <= rd_en && rd_valid;
            r_s1_range  <= rd_en && rd_range;
            r_s1_off    <= i_in_item.field_offset;
        end
    end

    // Field decode from RAM data
    always_comb begin
        fmask   = vbl_pkg::field_mask(r_s1_off);
        key_val = {rdata[7], rdata} - vbl_pkg::KEY_BIAS;
        n_out_item.status         = r_s1_status;
        n_out_item.imported_count = r_s1_count;
        n_out_item.field_valid    = r_s1_fvalid;
        if (r_s1_kind == vbl_pkg::KIND_READ && r_s1_range) begin
            if (r_s1_off == vbl_pkg::OFF_KEY) begin
                n_out_item.field_value = key_val;
            end else begin
                n_out_item.field_value = {1'b0, rdata & fmask};
            end
        end else begin
            n_out_item.field_value = 9'sd0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

FILE: test/sysex_bulk_voice_loader_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sysex_bulk_voice_loader_test: self-checking bench for the voice dump loader
// Streams bulk dumps, broken and short messages and field reads through the
// item channel. An in-bench copy of the loader (message checks, masked bank
// writes, bank swap, field decode) predicts every status and field answer,
// and each answer from the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module sysex_bulk_voice_loader_test;

    // Message layout as the loader sees it
    localparam int VOICE_SLOTS     = 32;
    localparam int RECORD_BYTES    = 76;
    localparam int DUMP_DATA_BYTES = VOICE_SLOTS * RECORD_BYTES;
    localparam int FIRST_VOICE_POS = 6;
    localparam int CKS_POS         = FIRST_VOICE_POS + DUMP_DATA_BYTES;
    localparam int MIN_DUMP_LEN    = DUMP_DATA_BYTES + 12;
    localparam int LEN_CAP         = 4095;
    localparam logic [6:0] COUNT_HI = 7'(DUMP_DATA_BYTES >> 7);
    localparam logic [6:0] COUNT_LO = 7'(DUMP_DATA_BYTES & 127);
    localparam logic [7:0] START_BYTE = 8'hF0;
    localparam logic [7:0] MAKER_BYTE = 8'h43;
    localparam logic [7:0] BULK_FMT   = 8'h09;
    localparam logic [7:0] CLOSE_BYTE = 8'hF7;
    localparam int KEY_FIELD = 9;

    // Bench timing
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 900;

    // How a generated bulk dump is spoilt, if at all
    typedef enum int {
        SHAPE_GOOD,
        SHAPE_BAD_START,
        SHAPE_BAD_MAKER,
        SHAPE_BAD_FORMAT,
        SHAPE_BAD_COUNT,
        SHAPE_BAD_SUM,
        SHAPE_SUM_HIGH,
        SHAPE_TRUNCATED,
        SHAPE_LONG
    } t_dump_shape;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    vbl_pkg::t_in_item  i_in_item   = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               i_cfg_data  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    vbl_pkg::t_out_item o_out_item;
    logic               o_cfg_ready;

    // Loader state as predicted by the bench
    logic [7:0]  voice_mem [0:2*DUMP_DATA_BYTES-1];
    logic        act_bank     = 1'b0;
    logic        have_voices  = 1'b0;
    int          msg_len      = 0;
    logic [6:0]  data_sum     = '0;
    logic [1:0]  hdr_bad      = '0;
    logic [13:0] decl_count   = '0;
    logic [7:0]  rx_cks       = '0;
    logic        protect_bit  = 1'b0;

    vbl_pkg::t_out_item loader_answers [$];
    logic [7:0] msg_bytes [$];
    int answer_errors   = 0;
    int answers_checked = 0;
    int items_sent      = 0;
    bit idle_on         = 1'b1;
    int hold_asked      = 0;

    sysex_bulk_voice_loader u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bits kept of each byte in a voice record
    function automatic logic [7:0] kept_bits(input int f);
        logic [7:0] m;
        m = 8'h00;
        if (f < 10) begin
            case (f)
                0, 1:    m = 8'h07;
                3, 4, 5: m = 8'h7F;
                6:       m = 8'h01;
                7:       m = 8'h03;
                8:       m = 8'h73;
                default: m = 8'hFF;
            endcase
        end else if (f < 74) begin
            case ((f - 10) % 16)
                0, 1, 2: m = 8'h1F;
                3, 4:    m = 8'h0F;
                5, 10:   m = 8'hFF;
                6:       m = 8'h03;
                7, 9:    m = 8'h07;
                12:      m = 8'h07;
                8:       m = 8'h01;
                11:      m = 8'h3F;
                default: m = 8'h00;
            endcase
        end
        return m;
    endfunction

    // Advance the loader by one item; returns 1 when the item is answered
    function automatic bit loader_step(input vbl_pkg::t_in_item it,
                                       output vbl_pkg::t_out_item ans);
        int               pos;
        int               base;
        logic [7:0]       b;
        vbl_pkg::t_status st;
        ans = '0;
        if (it.kind == vbl_pkg::KIND_BYTE) begin
            b   = it.data_byte;
            pos = msg_len;
            if (pos < LEN_CAP) begin
                msg_len = pos + 1;
                if (pos == 0 && b != START_BYTE) hdr_bad[0] = 1'b1;
                if (pos == 1 && b != MAKER_BYTE) hdr_bad[0] = 1'b1;
                if (pos == 3 && b != BULK_FMT)   hdr_bad[1] = 1'b1;
                if (pos == 4) decl_count = {b[6:0], 7'd0};
                if (pos == 5) decl_count = {decl_count[13:7], b[6:0]};
                if (pos >= FIRST_VOICE_POS && pos < CKS_POS) begin
                    data_sum = data_sum + b[6:0];
                    base = act_bank ? 0 : DUMP_DATA_BYTES;
                    voice_mem[base + pos - FIRST_VOICE_POS] =
                        b & kept_bits((pos - FIRST_VOICE_POS) % RECORD_BYTES);
                end
                if (pos == CKS_POS) rx_cks = b;
            end
            if (!it.end_of_message) return 1'b0;
            // checks in the order the loader applies them
            if (msg_len < 8)                        st = vbl_pkg::ST_SHORT;
            else if (hdr_bad[0])                    st = vbl_pkg::ST_HEADER;
            else if (hdr_bad[1])                    st = vbl_pkg::ST_FORMAT;
            else if (msg_len < 10)                  st = vbl_pkg::ST_SHORT;
            else if (decl_count != 14'(DUMP_DATA_BYTES)) st = vbl_pkg::ST_COUNT;
            else if (msg_len < MIN_DUMP_LEN)        st = vbl_pkg::ST_SHORT;
            else if (rx_cks != {1'b0, data_sum})    st = vbl_pkg::ST_CHECKSUM;
            else if (protect_bit)                   st = vbl_pkg::ST_PROTECTED;
            else                                    st = vbl_pkg::ST_OK;
            if (st == vbl_pkg::ST_OK) begin
                act_bank    = ~act_bank;
                have_voices = 1'b1;
            end
            msg_len    = 0;
            data_sum   = '0;
            hdr_bad    = '0;
            decl_count = '0;
            rx_cks     = '0;
            ans.status         = st;
            ans.imported_count = (st == vbl_pkg::ST_OK) ? 6'(VOICE_SLOTS) : 6'd0;
        end else begin
            ans.field_valid = have_voices && (it.voice_index < VOICE_SLOTS);
            if (ans.field_valid && it.field_offset < RECORD_BYTES) begin
                base = act_bank ? DUMP_DATA_BYTES : 0;
                b = voice_mem[base + it.voice_index * RECORD_BYTES + it.field_offset];
                if (it.field_offset == KEY_FIELD)
                    ans.field_value = {b[7], b} - 9'sd24;
                else
                    ans.field_value = {1'b0, b & kept_bits(it.field_offset)};
            end
        end
        return 1'b1;
    endfunction

    // Predict on accepted items, check accepted answers
    always @(posedge i_clk) begin : answer_check
        vbl_pkg::t_out_item want;
        vbl_pkg::t_out_item got;
        bit                 made;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) protect_bit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                made = loader_step(i_in_item, want);
                if (made) loader_answers.insert(loader_answers.size(), want);
            end
            if (o_out_valid && i_out_ready) begin
                got = o_out_item;
                answers_checked++;
                if (loader_answers.size() == 0) begin
                    if (answer_errors < 10)
                        $display("unexpected answer: status %0d count %0d value %0d valid %0b",
                                 got.status, got.imported_count, got.field_value,
                                 got.field_valid);
                    answer_errors++;
                end else begin
                    want = loader_answers.pop_front();
                    if (got.status !== want.status
                            || got.imported_count !== want.imported_count
                            || got.field_value !== want.field_value
                            || got.field_valid !== want.field_valid) begin
                        if (answer_errors < 10)
                            $display({"mismatch: want status %0d count %0d value %0d ",
                                      "valid %0b, got status %0d count %0d value %0d valid %0b"},
                                     want.status, want.imported_count, want.field_value,
                                     want.field_valid, got.status, got.imported_count,
                                     got.field_value, got.field_valid);
                        answer_errors++;
                    end
                end
            end
        end
    end

    // Answer side: random stall bursts, plus long hold-offs on request
    always @(posedge i_clk) begin : answer_sink
        int gap_left;
        int hold_left;
        int hold_served;
        if (!i_rst_n) begin
            gap_left    = 0;
            hold_left   = 0;
            hold_served = 0;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(1, 7) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Ends the run when nothing has moved for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Offer one item, with an occasional gap first, and wait for acceptance
    task automatic send_item(input vbl_pkg::t_in_item it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eom);
        vbl_pkg::t_in_item it;
        it                = vbl_pkg::t_in_item'($urandom);
        it.kind           = vbl_pkg::KIND_BYTE;
        it.data_byte      = b;
        it.end_of_message = eom;
        send_item(it);
    endtask

    task automatic send_read(input logic [4:0] vi, input logic [6:0] off);
        vbl_pkg::t_in_item it;
        it              = vbl_pkg::t_in_item'($urandom);
        it.kind         = vbl_pkg::KIND_READ;
        it.voice_index  = vi;
        it.field_offset = off;
        send_item(it);
    endtask

    task automatic send_random_read();
        send_read(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
    endtask

    // Send the staged message, end flag on its last byte, reads mixed in
    task automatic send_message(input int read_pct);
        for (int i = 0; i < msg_bytes.size(); i++) begin
            if ($urandom_range(0, 99) < read_pct) send_random_read();
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
    endtask

    // Sender pauses until every answer is in and the pipeline is empty
    task automatic wait_for_answers();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (loader_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_protect(input logic v);
        wait_for_answers();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Header byte of a well-formed dump; spare high bits and unchecked bytes are randomised
    function automatic logic [7:0] header_byte(input int i);
        case (i)
            0:       return START_BYTE;
            1:       return MAKER_BYTE;
            3:       return BULK_FMT;
            4:       return {1'($urandom), COUNT_HI};
            5:       return {1'($urandom), COUNT_LO};
            default: return 8'($urandom);
        endcase
    endfunction

    // Stage a bulk dump of the given shape in msg_bytes
    function automatic void build_dump(input t_dump_shape shape, input bit pin_keys,
                                       input int cut_len);
        logic [7:0] b;
        logic [6:0] total;
        int         stop_len;
        msg_bytes.delete();
        total = '0;
        for (int i = 0; i < FIRST_VOICE_POS; i++) begin
            b = header_byte(i);
            if (i == 0 && shape == SHAPE_BAD_START)  b = START_BYTE ^ 8'($urandom_range(1, 255));
            if (i == 1 && shape == SHAPE_BAD_MAKER)  b = MAKER_BYTE ^ 8'($urandom_range(1, 255));
            if (i == 3 && shape == SHAPE_BAD_FORMAT) b = BULK_FMT ^ 8'($urandom_range(1, 255));
            if (i == 5 && shape == SHAPE_BAD_COUNT)  b = b ^ 8'($urandom_range(1, 127));
            msg_bytes.insert(msg_bytes.size(), b);
        end
        for (int i = 0; i < DUMP_DATA_BYTES; i++) begin
            b = 8'($urandom);
            // most negative and most positive key offsets
            if (pin_keys && i == KEY_FIELD) b = 8'h80;
            if (pin_keys && i == (VOICE_SLOTS - 1) * RECORD_BYTES + KEY_FIELD) b = 8'h7F;
            total = total + b[6:0];
            msg_bytes.insert(msg_bytes.size(), b);
        end
        b = {1'b0, total};
        if (shape == SHAPE_BAD_SUM)  b = b ^ 8'($urandom_range(1, 255));
        if (shape == SHAPE_SUM_HIGH) b = {1'b1, total};
        msg_bytes.insert(msg_bytes.size(), b);
        stop_len = (shape == SHAPE_LONG) ? $urandom_range(LEN_CAP + 2, LEN_CAP + 100)
                                         : MIN_DUMP_LEN;
        while (msg_bytes.size() < stop_len - 1)
            msg_bytes.insert(msg_bytes.size(), 8'($urandom));
        msg_bytes.insert(msg_bytes.size(), CLOSE_BYTE);
        if (shape == SHAPE_TRUNCATED)
            while (msg_bytes.size() > cut_len) void'(msg_bytes.pop_back());
    endfunction

    task automatic test_reads_before_load();
        send_read(5'd0, 7'd0);
        send_read(5'd31, 7'd127);
        send_read(5'd0, 7'(KEY_FIELD));
        send_read(5'd31, 7'd75);
        wait_for_answers();
    endtask

    // Every early exit of the message checks on short messages
    task automatic test_short_messages();
        msg_bytes = '{CLOSE_BYTE};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h09, 8'h13, 8'h00, 8'h01};
        send_message(0);
        msg_bytes = '{8'h00, 8'h43, 8'h00, 8'h09, 8'h13, 8'h00, 8'h01, 8'hF7};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h42, 8'h00, 8'h09, 8'h13, 8'h00, 8'h01, 8'hF7};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h0A, 8'h13, 8'h00, 8'h01, 8'hF7};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h43, 8'hFF, 8'h09, 8'h13, 8'h00, 8'h01, 8'h02, 8'hF7};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h09, 8'h13, 8'h01, 8'h00, 8'h00, 8'h00, 8'hF7};
        send_message(0);
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h09, 8'h7F, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hF7};
        send_message(0);
        // high bits of the count bytes are dropped, so this count is right
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h09, 8'h93, 8'h80, 8'h00, 8'h00, 8'h00, 8'hF7};
        send_message(0);
        wait_for_answers();
    endtask

    // First good dump, then a sweep of every offset of voice 0
    task automatic test_good_dump();
        build_dump(SHAPE_GOOD, 1'b1, 0);
        send_message(1);
        for (int off = 0; off < 128; off++) send_read(5'd0, 7'(off));
        send_read(5'd31, 7'(KEY_FIELD));
        send_read(5'd31, 7'd0);
        wait_for_answers();
    endtask

    // Dumps that fail late must leave the loaded voices in place
    task automatic test_rejected_dumps();
        build_dump(SHAPE_BAD_SUM, 1'b0, 0);
        send_message(3);
        build_dump(SHAPE_SUM_HIGH, 1'b0, 0);
        send_message(3);
        build_dump(SHAPE_TRUNCATED, 1'b0, MIN_DUMP_LEN - 1);
        send_message(3);
        for (int i = 0; i < 20; i++) send_random_read();
        wait_for_answers();
    endtask

    task automatic test_memory_protect();
        write_protect(1'b1);
        build_dump(SHAPE_GOOD, 1'b0, 0);
        send_message(2);
        for (int i = 0; i < 10; i++) send_random_read();
        write_protect(1'b0);
        build_dump(SHAPE_GOOD, 1'b1, 0);
        send_message(2);
        for (int i = 0; i < 10; i++) send_random_read();
        wait_for_answers();
    endtask

    // Length counter saturates; bytes past the checksum are ignored
    task automatic test_long_message();
        build_dump(SHAPE_LONG, 1'b0, 0);
        send_message(1);
        for (int i = 0; i < 10; i++) send_random_read();
        wait_for_answers();
    endtask

    // Answer side holds off while reads keep coming, so the input stalls
    task automatic test_back_pressure();
        hold_asked++;
        for (int i = 0; i < 200; i++) send_random_read();
        wait_for_answers();
    endtask

    task automatic test_random();
        int          first_item;
        int          dumps;
        int          pick;
        int          n;
        bit          framed;
        t_dump_shape shape;
        first_item = items_sent;
        dumps      = 0;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25 && dumps < 5) begin
                if ($urandom_range(0, 1)) shape = SHAPE_GOOD;
                else shape = t_dump_shape'($urandom_range(SHAPE_BAD_START, SHAPE_LONG));
                build_dump(shape, 1'b0, $urandom_range(10, MIN_DUMP_LEN - 1));
                send_message($urandom_range(0, 4));
                dumps++;
            end else if (pick < 60) begin
                repeat ($urandom_range(5, 20)) send_random_read();
            end else if (pick < 92) begin
                // short message, often starting with a proper header
                n = $urandom_range(1, 16);
                framed = $urandom_range(0, 1);
                msg_bytes.delete();
                for (int i = 0; i < n; i++)
                    msg_bytes.insert(msg_bytes.size(),
                                     (framed && i < FIRST_VOICE_POS) ? header_byte(i)
                                                                     : 8'($urandom));
                send_message(10);
            end else begin
                write_protect($urandom_range(0, 3) == 0);
            end
        end
        write_protect(1'b0);
        // closing stretch with no idling on either side
        idle_on = 1'b0;
        for (int i = 0; i < 40; i++) send_random_read();
        msg_bytes = '{8'hF0, 8'h43, 8'h00, 8'h09};
        send_message(0);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_protect(1'b0);
        test_reads_before_load();
        test_short_messages();
        test_good_dump();
        test_rejected_dumps();
        test_memory_protect();
        test_long_message();
        test_back_pressure();
        test_random();
        wait_for_answers();
        if (answer_errors == 0 && loader_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
